@@ src/mvsm_pkg.sv @@
package mvsm_pkg;

  localparam int VOICES       = 7;
  localparam int REGION_BYTES = 16384;
  localparam int REPEAT_SHIFT = 3;

  localparam int STORE_BYTES = VOICES * REGION_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam int KIND_W  = 2;
  localparam int VOICE_W = 3;
  localparam int OFS_W   = 14;
  localparam int DATA_W  = 15;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 8;
  localparam int ACNT_W  = 3;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LEN_W  = $clog2(REGION_BYTES + 1);
  localparam int POS_W  = $clog2(REGION_BYTES) + REPEAT_SHIFT;
  localparam int LIM_W  = LEN_W + REPEAT_SHIFT;
  localparam int SUM_W  = $clog2(VOICES * 255 + 1);
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int REM_W  = CNT_W + 1;
  localparam int ITER_W = $clog2(SUM_W + 1);

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/mvsm_ram.sv @@
module mvsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/mvsm_div.sv @@
module mvsm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mvsm_pkg::SUM_W-1:0]    dividend,
  input  logic [mvsm_pkg::CNT_W-1:0]    divisor,
  output logic [mvsm_pkg::LEVEL_W-1:0]  quotient,
  output mvsm_pkg::div_stat_t           stat
);

  logic [mvsm_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [mvsm_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [mvsm_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [mvsm_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [mvsm_pkg::REM_W-1:0]  shifted;
  logic                        ge;

  always_comb begin
    shifted  = {rem_r[mvsm_pkg::REM_W-2:0], quo_r[mvsm_pkg::SUM_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      iter_nxt = mvsm_pkg::ITER_W'(mvsm_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_nxt  = {quo_r[mvsm_pkg::SUM_W-2:0], ge};
      iter_nxt = iter_r - mvsm_pkg::ITER_W'(1);
      if (iter_r == mvsm_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r[mvsm_pkg::LEVEL_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ src/multi_voice_sample_mixer.sv @@
// Seven-voice sample playback mixer. Each input transaction is a tick, a voice
// start, a sample byte write or a clip length write. Start and write
// transactions complete in the cycle they are accepted and produce no result.
// A tick walks the voices one per cycle through the sample RAM read port,
// then a shared restoring divider forms sum / count one quotient bit per
// cycle; in_ready stays low from the acceptance of a tick until its result
// is written to the output register. Results sit in that output register,
// so new transactions, ticks included, are taken while a result waits.
module multi_voice_sample_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mvsm_pkg::KIND_W-1:0]   in_kind,
  input  logic [mvsm_pkg::VOICE_W-1:0]  in_voice,
  input  logic [mvsm_pkg::OFS_W-1:0]    in_address,
  input  logic [mvsm_pkg::DATA_W-1:0]   in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mvsm_pkg::LEVEL_W-1:0]  out_level,
  output logic [mvsm_pkg::ACNT_W-1:0]   out_active_count
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_FLUSH = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic                         active_r   [mvsm_pkg::VOICES];
  logic                         active_nxt [mvsm_pkg::VOICES];
  logic [mvsm_pkg::POS_W-1:0]   pos_r      [mvsm_pkg::VOICES];
  logic [mvsm_pkg::POS_W-1:0]   pos_nxt    [mvsm_pkg::VOICES];
  logic [mvsm_pkg::LEN_W-1:0]   len_r      [mvsm_pkg::VOICES];
  logic [mvsm_pkg::LEN_W-1:0]   len_nxt    [mvsm_pkg::VOICES];

  logic [mvsm_pkg::VIDX_W-1:0]  walk_r, walk_nxt;
  logic [mvsm_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [mvsm_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         add_pend_r, add_pend_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [mvsm_pkg::LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [mvsm_pkg::ACNT_W-1:0]  out_count_r, out_count_nxt;

  logic                         in_fire;
  logic                         voice_ok;
  logic [mvsm_pkg::VIDX_W-1:0]  vsel;
  logic [mvsm_pkg::LEN_W-1:0]   len_sat;
  logic                         ram_we;
  logic [mvsm_pkg::ADDR_W-1:0]  ram_waddr;
  logic                         ram_re;
  logic [mvsm_pkg::ADDR_W-1:0]  ram_raddr;
  logic [mvsm_pkg::BYTE_W-1:0]  ram_rdata;
  logic [mvsm_pkg::LIM_W-1:0]   pos_inc;
  logic [mvsm_pkg::LIM_W-1:0]   limit;
  logic [mvsm_pkg::SUM_W-1:0]   sum_acc;
  logic                         div_start;
  logic [mvsm_pkg::LEVEL_W-1:0] div_quo;
  mvsm_pkg::div_stat_t          div_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign voice_ok = in_voice < mvsm_pkg::VOICE_W'(mvsm_pkg::VOICES);
  assign vsel     = mvsm_pkg::VIDX_W'(in_voice);
  assign len_sat  = (in_data > mvsm_pkg::DATA_W'(mvsm_pkg::REGION_BYTES))
                    ? mvsm_pkg::LEN_W'(mvsm_pkg::REGION_BYTES)
                    : mvsm_pkg::LEN_W'(in_data);

  assign ram_we    = in_fire && (in_kind == mvsm_pkg::KIND_SAMPLE) && voice_ok
                     && (32'(in_address) < mvsm_pkg::REGION_BYTES);
  assign ram_waddr = mvsm_pkg::ADDR_W'(in_voice) * mvsm_pkg::ADDR_W'(mvsm_pkg::REGION_BYTES)
                     + mvsm_pkg::ADDR_W'(in_address);

  assign pos_inc   = mvsm_pkg::LIM_W'(pos_r[walk_r]) + mvsm_pkg::LIM_W'(1);
  assign limit     = mvsm_pkg::LIM_W'(len_r[walk_r]) << mvsm_pkg::REPEAT_SHIFT;
  assign ram_re    = (state_r == S_WALK) && active_r[walk_r] && (pos_inc < limit);
  assign ram_raddr = mvsm_pkg::ADDR_W'(walk_r) * mvsm_pkg::ADDR_W'(mvsm_pkg::REGION_BYTES)
                     + mvsm_pkg::ADDR_W'(pos_r[walk_r] >> mvsm_pkg::REPEAT_SHIFT);
  assign sum_acc   = sum_r + (add_pend_r ? mvsm_pkg::SUM_W'(ram_rdata) : '0);
  assign div_start = (state_r == S_FLUSH);

  mvsm_ram #(
    .WIDTH (mvsm_pkg::BYTE_W),
    .DEPTH (mvsm_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data[mvsm_pkg::BYTE_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mvsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (count_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    walk_nxt      = walk_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    add_pend_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_count_nxt = out_count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            mvsm_pkg::KIND_TICK: begin
              walk_nxt  = '0;
              sum_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_WALK;
            end
            mvsm_pkg::KIND_START: begin
              if (voice_ok) begin
                active_nxt[vsel] = 1'b1;
                pos_nxt[vsel]    = '0;
              end
            end
            mvsm_pkg::KIND_LENGTH: begin
              if (voice_ok) begin
                len_nxt[vsel] = len_sat;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        sum_nxt = sum_acc;
        if (active_r[walk_r]) begin
          count_nxt = count_r + mvsm_pkg::CNT_W'(1);
          if (pos_inc < limit) begin
            pos_nxt[walk_r] = mvsm_pkg::POS_W'(pos_inc);
            add_pend_nxt    = 1'b1;
          end else begin
            active_nxt[walk_r] = 1'b0;
          end
        end
        if (walk_r == mvsm_pkg::VIDX_W'(mvsm_pkg::VOICES - 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          walk_nxt = walk_r + mvsm_pkg::VIDX_W'(1);
        end
      end
      S_FLUSH: begin
        sum_nxt   = sum_acc;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (count_r == '0) ? '0 : div_quo;
          out_count_nxt = mvsm_pkg::ACNT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      add_pend_r  <= 1'b0;
      for (int i = 0; i < mvsm_pkg::VOICES; i++) begin
        active_r[i] <= 1'b0;
        pos_r[i]    <= '0;
        len_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      add_pend_r  <= add_pend_nxt;
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
    end
    walk_r      <= walk_nxt;
    sum_r       <= sum_nxt;
    count_r     <= count_nxt;
    out_level_r <= out_level_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_active_count = out_count_r;

`ifndef SYNTHESIS
  a_zero_count_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_active_count == '0) |-> out_level == '0)
    else $error("nonzero level with no active voice");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> walk_r <= mvsm_pkg::VIDX_W'(mvsm_pkg::VOICES - 1))
    else $error("voice walk index out of range");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> count_r <= mvsm_pkg::CNT_W'(mvsm_pkg::VOICES))
    else $error("active count exceeds voice count");
`endif

endmodule
